### rtl/slrt_pkg.sv
package slrt_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int OP_BITS    = 3;
    localparam int STAT_BITS  = 3;
    localparam int CNT_BITS   = 6;
    localparam int FILL_BITS  = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 4;

    localparam logic [FILL_BITS-1:0] MIN_FILL_RST = 4'd2;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_LOOKUP   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_TAKE_MIN = 3'd3;
    localparam logic [OP_BITS-1:0] OP_TAKE_MAX = 3'd4;

    // result status codes
    localparam logic [STAT_BITS-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_REPLACED  = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_FOUND     = 3'd4;
    localparam logic [STAT_BITS-1:0] ST_TAKEN     = 3'd5;
    localparam logic [STAT_BITS-1:0] ST_NOT_RICH  = 3'd6;
    localparam logic [STAT_BITS-1:0] ST_NO_ROOM   = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_FILL  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROOT_MODE = 1'b1;

    typedef struct packed {
        logic [OP_BITS-1:0]    operation;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [KEY_BITS-1:0]   out_key;
        logic [VALUE_BITS-1:0] out_value;
        logic [CNT_BITS-1:0]   record_count;
        logic [KEY_BITS-1:0]   least_key;
        logic [KEY_BITS-1:0]   greatest_key;
        logic                  is_full;
        logic                  is_poor;
        logic                  is_rich;
    } t_out_item;

    // per-beat command broadcast to every cell
    typedef struct packed {
        logic ins;   // insert new record at first slot not below key
        logic rep;   // replace value in matching slot
        logic del;   // close gap at matching slot
        logic pop;   // shift whole row toward slot 0
    } t_cell_ctl;

endpackage

### rtl/slrt_cell.sv
module slrt_cell (
    input  logic                                i_clk,
    input  slrt_pkg::t_cell_ctl                 i_ctl,
    input  logic                                i_occ,
    input  logic                                i_lt_left,
    input  logic [slrt_pkg::KEY_BITS-1:0]       i_key,
    input  logic [slrt_pkg::VALUE_BITS-1:0]     i_value,
    input  logic [slrt_pkg::KEY_BITS-1:0]       i_left_key,
    input  logic [slrt_pkg::VALUE_BITS-1:0]     i_left_value,
    input  logic [slrt_pkg::KEY_BITS-1:0]       i_right_key,
    input  logic [slrt_pkg::VALUE_BITS-1:0]     i_right_value,
    output logic [slrt_pkg::KEY_BITS-1:0]       o_key,
    output logic [slrt_pkg::VALUE_BITS-1:0]     o_value,
    output logic                                o_lt,
    output logic                                o_eq
);

    logic [slrt_pkg::KEY_BITS-1:0]   r_key;
    logic [slrt_pkg::VALUE_BITS-1:0] r_value;
    logic [slrt_pkg::KEY_BITS-1:0]   n_key;
    logic [slrt_pkg::VALUE_BITS-1:0] n_value;
    logic                            lt;
    logic                            eq;

    assign lt = i_occ && (r_key < i_key);
    assign eq = i_occ && (r_key == i_key);

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        priority if (i_ctl.ins && !lt) begin
            // first non-smaller slot takes the new record, the rest move right
            if (i_lt_left) begin
                n_key   = i_key;
                n_value = i_value;
            end else begin
                n_key   = i_left_key;
                n_value = i_left_value;
            end
        end else if (i_ctl.pop || (i_ctl.del && !lt)) begin
            n_key   = i_right_key;
            n_value = i_right_value;
        end else if (i_ctl.rep && eq) begin
            n_value = i_value;
        end else begin
            // idle: hold the record
            n_key   = r_key;
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = lt;
    assign o_eq    = eq;

endmodule

### rtl/sorted_leaf_record_table_top.sv
// Each input beat updates the cell row and the mid-stage registers, then moves into the result register.
// Throughput: one item per cycle while the result side does not stall; all cells
// compare and shift in parallel, and the end keys are read from the updated row.
// Reset (i_rst_n low, synchronous): record count zero, min_fill 2, root_mode 0,
// both stages empty. Record storage is not cleared; slots above the count are never read.
module sorted_leaf_record_table_top #(
    parameter int SLOTS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  slrt_pkg::t_in_item                      i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output slrt_pkg::t_out_item                     o_out_data,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [slrt_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [slrt_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int FW = (CW > 5) ? CW + 1 : 6;
    localparam int KB = slrt_pkg::KEY_BITS;
    localparam int VB = slrt_pkg::VALUE_BITS;

    logic [slrt_pkg::FILL_BITS-1:0] r_min_fill;
    logic                           r_root_mode;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;

    logic                             r_mid_valid;
    logic [slrt_pkg::STAT_BITS-1:0]   r_mid_status;
    logic [KB-1:0]                    r_mid_key;
    logic [VB-1:0]                    r_mid_value;
    logic [slrt_pkg::STAT_BITS-1:0]   n_mid_status;
    logic [KB-1:0]                    n_mid_key;
    logic [VB-1:0]                    n_mid_value;

    logic                r_out_valid;
    slrt_pkg::t_out_item r_out;
    slrt_pkg::t_out_item n_out;

    logic in_acc;
    logic mid_move;

    logic [KB-1:0]    cell_key   [SLOTS];
    logic [VB-1:0]    cell_value [SLOTS];
    logic [SLOTS-1:0] occ;
    logic [SLOTS-1:0] lt;
    logic [SLOTS-1:0] eq;
    logic [SLOTS-1:0] last;

    logic [KB-1:0] hit_value_key;
    logic [VB-1:0] hit_value;
    logic [KB-1:0] last_key;
    logic [VB-1:0] last_value;

    logic                hit;
    logic                room;
    logic                rich_now;
    logic                can_take;
    slrt_pkg::t_cell_ctl ctl;

    logic [FW-1:0]    cnt_f;
    logic [FW-1:0]    fill_f;
    logic [FW-1:0]    twice_f;
    logic [CW+5:0]    cnt_ext;

    assign mid_move   = r_mid_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_mid_valid && !mid_move;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // row of cells
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign occ[g]  = (CW'(g) < r_count);
        assign last[g] = (CW'(g + 1) == r_count);

        if (g == 0) begin : g_first
            slrt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occ        (occ[g]),
                .i_lt_left    (1'b1),
                .i_key        (i_in_data.key),
                .i_value      (i_in_data.value),
                .i_left_key   (i_in_data.key),
                .i_left_value (i_in_data.value),
                .i_right_key  (cell_key[g+1]),
                .i_right_value(cell_value[g+1]),
                .o_key        (cell_key[g]),
                .o_value      (cell_value[g]),
                .o_lt         (lt[g]),
                .o_eq         (eq[g])
            );
        end else if (g == SLOTS - 1) begin : g_last
            slrt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occ        (occ[g]),
                .i_lt_left    (lt[g-1]),
                .i_key        (i_in_data.key),
                .i_value      (i_in_data.value),
                .i_left_key   (cell_key[g-1]),
                .i_left_value (cell_value[g-1]),
                .i_right_key  ('0),
                .i_right_value('0),
                .o_key        (cell_key[g]),
                .o_value      (cell_value[g]),
                .o_lt         (lt[g]),
                .o_eq         (eq[g])
            );
        end else begin : g_mid
            slrt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occ        (occ[g]),
                .i_lt_left    (lt[g-1]),
                .i_key        (i_in_data.key),
                .i_value      (i_in_data.value),
                .i_left_key   (cell_key[g-1]),
                .i_left_value (cell_value[g-1]),
                .i_right_key  (cell_key[g+1]),
                .i_right_value(cell_value[g+1]),
                .o_key        (cell_key[g]),
                .o_value      (cell_value[g]),
                .o_lt         (lt[g]),
                .o_eq         (eq[g])
            );
        end
    end

    // one-hot selects over the row
    always_comb begin
        hit_value_key = '0;
        hit_value     = '0;
        last_key      = '0;
        last_value    = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_value_key = hit_value_key | (eq[i] ? cell_key[i] : '0);
            hit_value     = hit_value | (eq[i] ? cell_value[i] : '0);
            last_key      = last_key | (last[i] ? cell_key[i] : '0);
            last_value    = last_value | (last[i] ? cell_value[i] : '0);
        end
    end

    assign hit     = |eq;
    assign room    = (r_count != CW'(SLOTS));
    assign cnt_f   = FW'(r_count);
    assign fill_f  = FW'(r_min_fill);
    assign twice_f = FW'({r_min_fill, 1'b0});
    assign rich_now = r_root_mode ? (cnt_f > FW'(1)) : (cnt_f > fill_f);
    assign can_take = rich_now && (r_count != '0);

    always_comb begin
        ctl          = '0;
        n_mid_status = slrt_pkg::ST_NOT_FOUND;
        n_mid_key    = '0;
        n_mid_value  = '0;
        n_count      = r_count;
        unique case (i_in_data.operation)
            slrt_pkg::OP_INSERT: begin
                if (hit) begin
                    ctl.rep      = in_acc;
                    n_mid_status = slrt_pkg::ST_REPLACED;
                end else if (!room) begin
                    n_mid_status = slrt_pkg::ST_NO_ROOM;
                end else begin
                    ctl.ins      = in_acc;
                    n_mid_status = slrt_pkg::ST_INSERTED;
                    n_count      = r_count + 1'b1;
                end
            end
            slrt_pkg::OP_REMOVE: begin
                if (hit) begin
                    ctl.del      = in_acc;
                    n_mid_status = slrt_pkg::ST_REMOVED;
                    n_mid_key    = hit_value_key;
                    n_mid_value  = hit_value;
                    n_count      = r_count - 1'b1;
                end
            end
            slrt_pkg::OP_LOOKUP: begin
                n_mid_status = hit ? slrt_pkg::ST_FOUND : slrt_pkg::ST_NOT_FOUND;
            end
            slrt_pkg::OP_TAKE_MIN: begin
                if (can_take) begin
                    ctl.pop      = in_acc;
                    n_mid_status = slrt_pkg::ST_TAKEN;
                    n_mid_key    = cell_key[0];
                    n_mid_value  = cell_value[0];
                    n_count      = r_count - 1'b1;
                end else begin
                    n_mid_status = slrt_pkg::ST_NOT_RICH;
                end
            end
            slrt_pkg::OP_TAKE_MAX: begin
                // dropping the top slot is just a count decrement
                if (can_take) begin
                    n_mid_status = slrt_pkg::ST_TAKEN;
                    n_mid_key    = last_key;
                    n_mid_value  = last_value;
                    n_count      = r_count - 1'b1;
                end else begin
                    n_mid_status = slrt_pkg::ST_NOT_RICH;
                end
            end
            default: begin
                n_mid_status = slrt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // result beat built from the row as it stands after the item's update
    assign cnt_ext = {6'd0, r_count};

    always_comb begin
        n_out              = r_out;
        n_out.status       = r_mid_status;
        n_out.out_key      = r_mid_key;
        n_out.out_value    = r_mid_value;
        n_out.record_count = cnt_ext[slrt_pkg::CNT_BITS-1:0];
        n_out.least_key    = (r_count != '0) ? cell_key[0] : '0;
        n_out.greatest_key = last_key;
        n_out.is_full      = (cnt_f > twice_f);
        n_out.is_poor      = r_root_mode ? (r_count == '0) : (cnt_f < fill_f);
        n_out.is_rich      = rich_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fill  <= slrt_pkg::MIN_FILL_RST;
            r_root_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                slrt_pkg::CFG_MIN_FILL:  r_min_fill  <= i_cfg_data;
                slrt_pkg::CFG_ROOT_MODE: r_root_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count <= n_count;
            end
            if (in_acc) begin
                r_mid_valid <= 1'b1;
            end else if (mid_move) begin
                r_mid_valid <= 1'b0;
            end
            if (mid_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid_status <= n_mid_status;
            r_mid_key    <= n_mid_key;
            r_mid_value  <= n_mid_value;
        end
        if (mid_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("record count above slot count");

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(eq))
        else $error("search key matches more than one slot");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_mid_valid && r_out_valid))
        else $error("input stalled with a free stage");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ctl.ins) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    a_mid_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_valid && !mid_move) |=> r_mid_valid)
        else $error("held result dropped before moving out");
`endif

endmodule

### tb/leaf_table_checker.sv
module leaf_table_checker #(
    parameter int SLOTS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  slrt_pkg::t_in_item                      i_in_data,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  slrt_pkg::t_out_item                     i_out_data,
    input  logic                                    i_cfg_valid,
    input  logic                                    i_cfg_ready,
    input  logic [slrt_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [slrt_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    output int                                      o_errors,
    output int                                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the leaf: records sorted ascending in slots 0 .. leaf_count-1
    logic [slrt_pkg::KEY_BITS-1:0]   leaf_keys [SLOTS];
    logic [slrt_pkg::VALUE_BITS-1:0] leaf_vals [SLOTS];
    int                              leaf_count;
    logic [slrt_pkg::FILL_BITS-1:0]  leaf_order;
    logic                            leaf_is_root;

    slrt_pkg::t_out_item leaf_results_due [$];
    int                  mismatches;

    initial begin
        mismatches = 0;
        o_errors   = 0;
        o_pending  = 0;
    end

    function automatic bit leaf_rich();
        return leaf_is_root ? (leaf_count > 1) : (leaf_count > int'(leaf_order));
    endfunction

    function automatic void close_gap(input int pos);
        for (int i = pos; i + 1 < leaf_count; i++) begin
            leaf_keys[i] = leaf_keys[i + 1];
            leaf_vals[i] = leaf_vals[i + 1];
        end
        leaf_count--;
    endfunction

    function automatic slrt_pkg::t_out_item apply_leaf_op(input slrt_pkg::t_in_item it);
        slrt_pkg::t_out_item r;
        int                  pos;
        bit                  hit;
        r   = '0;
        pos = 0;
        while (pos < leaf_count && leaf_keys[pos] < it.key)
            pos++;
        hit      = (pos < leaf_count) && (leaf_keys[pos] == it.key);
        r.status = slrt_pkg::ST_NOT_FOUND;
        case (it.operation)
            slrt_pkg::OP_INSERT: begin
                if (hit) begin
                    leaf_vals[pos] = it.value;
                    r.status = slrt_pkg::ST_REPLACED;
                end else if (leaf_count >= SLOTS) begin
                    r.status = slrt_pkg::ST_NO_ROOM;
                end else begin
                    for (int i = leaf_count; i > pos; i--) begin
                        leaf_keys[i] = leaf_keys[i - 1];
                        leaf_vals[i] = leaf_vals[i - 1];
                    end
                    leaf_keys[pos] = it.key;
                    leaf_vals[pos] = it.value;
                    leaf_count++;
                    r.status = slrt_pkg::ST_INSERTED;
                end
            end
            slrt_pkg::OP_REMOVE: begin
                if (hit) begin
                    r.out_key   = leaf_keys[pos];
                    r.out_value = leaf_vals[pos];
                    close_gap(pos);
                    r.status = slrt_pkg::ST_REMOVED;
                end
            end
            slrt_pkg::OP_LOOKUP: begin
                r.status = hit ? slrt_pkg::ST_FOUND : slrt_pkg::ST_NOT_FOUND;
            end
            slrt_pkg::OP_TAKE_MIN, slrt_pkg::OP_TAKE_MAX: begin
                if (leaf_rich() && leaf_count > 0) begin
                    pos = (it.operation == slrt_pkg::OP_TAKE_MIN) ? 0 : leaf_count - 1;
                    r.out_key   = leaf_keys[pos];
                    r.out_value = leaf_vals[pos];
                    close_gap(pos);
                    r.status = slrt_pkg::ST_TAKEN;
                end else begin
                    r.status = slrt_pkg::ST_NOT_RICH;
                end
            end
            default: r.status = slrt_pkg::ST_NOT_FOUND;
        endcase
        r.record_count = slrt_pkg::CNT_BITS'(leaf_count);
        r.least_key    = (leaf_count > 0) ? leaf_keys[0] : '0;
        r.greatest_key = (leaf_count > 0) ? leaf_keys[leaf_count - 1] : '0;
        r.is_full      = leaf_count > 2 * int'(leaf_order);
        r.is_poor      = leaf_is_root ? (leaf_count == 0) : (leaf_count < int'(leaf_order));
        r.is_rich      = leaf_rich();
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: result %s mismatch: expected %0h, got %0h", $realtime, field,
                     want, got);
    endtask

    always @(posedge i_clk) begin
        slrt_pkg::t_out_item want;
        slrt_pkg::t_out_item got;
        if (!i_rst_n) begin
            leaf_count   = 0;
            leaf_order   = slrt_pkg::MIN_FILL_RST;
            leaf_is_root = 1'b0;
            leaf_results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == slrt_pkg::CFG_MIN_FILL)
                    leaf_order = i_cfg_data[slrt_pkg::FILL_BITS-1:0];
                else if (i_cfg_index == slrt_pkg::CFG_ROOT_MODE)
                    leaf_is_root = i_cfg_data[0];
            end
            if (i_in_valid && !i_in_stall)
                leaf_results_due = {leaf_results_due, apply_leaf_op(i_in_data)};
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (leaf_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing outstanding: %h", $realtime,
                                 got);
                end else begin
                    want = leaf_results_due.pop_front();
                    if (got.status !== want.status)
                        flag_field("status", 64'(want.status), 64'(got.status));
                    if (got.out_key !== want.out_key)
                        flag_field("out_key", 64'(want.out_key), 64'(got.out_key));
                    if (got.out_value !== want.out_value)
                        flag_field("out_value", 64'(want.out_value), 64'(got.out_value));
                    if (got.record_count !== want.record_count)
                        flag_field("record_count", 64'(want.record_count),
                                   64'(got.record_count));
                    if (got.least_key !== want.least_key)
                        flag_field("least_key", 64'(want.least_key), 64'(got.least_key));
                    if (got.greatest_key !== want.greatest_key)
                        flag_field("greatest_key", 64'(want.greatest_key),
                                   64'(got.greatest_key));
                    if (got.is_full !== want.is_full)
                        flag_field("is_full", 64'(want.is_full), 64'(got.is_full));
                    if (got.is_poor !== want.is_poor)
                        flag_field("is_poor", 64'(want.is_poor), 64'(got.is_poor));
                    if (got.is_rich !== want.is_rich)
                        flag_field("is_rich", 64'(want.is_rich), 64'(got.is_rich));
                end
            end
        end
        o_pending <= leaf_results_due.size();
        o_errors  <= mismatches;
    end

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAF_SLOTS  = 32;
    localparam int KEY_POOL    = 44;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 192;
    localparam int CYCLE_LIMIT = 300000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    slrt_pkg::t_in_item                  i_in_data;
    logic                                o_out_valid;
    logic                                i_out_stall;
    slrt_pkg::t_out_item                 o_out_data;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [slrt_pkg::CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [slrt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    int error_count;
    int results_pending;
    int idle_pct;
    int stall_pct;
    int stall_hold;
    int cycle_count;

    logic [slrt_pkg::KEY_BITS-1:0] key_pool [KEY_POOL];

    sorted_leaf_record_table_top #(
        .SLOTS(LEAF_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    leaf_table_checker #(
        .SLOTS(LEAF_SLOTS)
    ) checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_errors   (error_count),
        .o_pending  (results_pending)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        stall_hold  = 0;
        cycle_count = 0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: long hold-off first, otherwise random stall
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold = stall_hold - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // leaves valid high after the beat; caller lowers it
    task automatic send_item(input slrt_pkg::t_in_item it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_op(input logic [slrt_pkg::OP_BITS-1:0] op,
                           input logic [slrt_pkg::KEY_BITS-1:0] k,
                           input logic [slrt_pkg::VALUE_BITS-1:0] v);
        slrt_pkg::t_in_item it;
        it.operation = op;
        it.key       = k;
        it.value     = v;
        send_item(it);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [slrt_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [slrt_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // growing stretches favor inserts, shrinking ones favor removes and takes
    function automatic slrt_pkg::t_in_item random_leaf_op(input bit growing);
        slrt_pkg::t_in_item it;
        int                 r;
        r = $urandom_range(99);
        if (growing)
            it.operation = (r < 70) ? slrt_pkg::OP_INSERT :
                           (r < 80) ? slrt_pkg::OP_REMOVE :
                           (r < 88) ? slrt_pkg::OP_LOOKUP :
                           (r < 92) ? slrt_pkg::OP_TAKE_MIN :
                           (r < 96) ? slrt_pkg::OP_TAKE_MAX :
                           slrt_pkg::OP_BITS'($urandom_range(5, 7));
        else
            it.operation = (r < 20) ? slrt_pkg::OP_INSERT :
                           (r < 55) ? slrt_pkg::OP_REMOVE :
                           (r < 65) ? slrt_pkg::OP_LOOKUP :
                           (r < 80) ? slrt_pkg::OP_TAKE_MIN :
                           (r < 95) ? slrt_pkg::OP_TAKE_MAX :
                           slrt_pkg::OP_BITS'($urandom_range(5, 7));
        it.key   = ($urandom_range(99) < 80) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                             : slrt_pkg::KEY_BITS'($urandom);
        it.value = slrt_pkg::VALUE_BITS'($urandom);
        return it;
    endfunction

    task automatic run_phase(input int phase, input int n_items);
        case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 15; stall_pct = 15; end
        endcase
        for (int i = 0; i < n_items; i++) begin
            // first phase: long result hold-off while beats keep coming
            if (phase == 0 && i == 20)
                stall_hold = 80;
            if (phase % 2 == 1 && i == n_items / 2) begin
                stop_sending();
                wait_drained();
            end
            send_item(random_leaf_op(((i / 48) % 2) == 0));
        end
        stop_sending();
        wait_drained();
    endtask

    initial begin
        logic [slrt_pkg::FILL_BITS-1:0] fill_set [PHASES];
        logic                           root_set [PHASES];
        fill_set = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd3, 4'd7, 4'd15};
        root_set = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = slrt_pkg::KEY_BITS'($urandom);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty leaf, end keys, replace, hits and misses, takes, unknown codes
        send_op(slrt_pkg::OP_LOOKUP, 32'h0, 32'h0);
        send_op(slrt_pkg::OP_REMOVE, 32'h5, 32'h0);
        send_op(slrt_pkg::OP_TAKE_MIN, 32'h0, 32'h0);
        send_op(slrt_pkg::OP_TAKE_MAX, 32'h0, 32'h0);
        send_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(slrt_pkg::OP_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_op(slrt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_op(slrt_pkg::OP_INSERT, 32'h8000_0000, 32'h1234_5678);
        send_op(slrt_pkg::OP_INSERT, 32'h0, 32'hA5A5_5A5A);
        send_op(slrt_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_op(slrt_pkg::OP_LOOKUP, 32'h1, 32'h0);
        send_op(slrt_pkg::OP_TAKE_MIN, 32'h0, 32'h0);
        send_op(slrt_pkg::OP_TAKE_MAX, 32'h0, 32'h0);
        send_op(slrt_pkg::OP_INSERT, 32'h5, 32'h0000_0055);
        send_op(slrt_pkg::OP_TAKE_MAX, 32'h0, 32'h0);
        send_op(slrt_pkg::OP_REMOVE, 32'h8000_0000, 32'h0);
        send_op(slrt_pkg::OP_REMOVE, 32'h8000_0000, 32'h0);
        send_op(3'd5, 32'h5, 32'h0);
        send_op(3'd6, 32'h5, 32'h0);
        stop_sending();
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(slrt_pkg::CFG_MIN_FILL, slrt_pkg::CFG_DATA_BITS'(fill_set[p]));
            write_reg(slrt_pkg::CFG_ROOT_MODE, slrt_pkg::CFG_DATA_BITS'(root_set[p]));
            run_phase(p, PHASE_ITEMS);
        end

        repeat (6) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/slrt_pkg.sv
rtl/slrt_cell.sv
rtl/sorted_leaf_record_table_top.sv
tb/leaf_table_checker.sv
tb/tb.sv
